@@ rtl/core/epcal_pkg.sv @@
`default_nettype none

package epcal_pkg;

  localparam logic [11:0] BASE_YEAR    = 12'd1970;
  localparam logic [31:0] DAY_SECS     = 32'd86400;
  localparam logic [31:0] HOUR_SECS    = 32'd3600;
  localparam logic [31:0] MIN_SECS     = 32'd60;
  localparam logic [31:0] YEAR_SECS    = 32'd365 * DAY_SECS;
  localparam logic [31:0] LEAP_SECS    = 32'd366 * DAY_SECS;
  localparam logic [3:0]  LAST_MONTH   = 4'd11;

  // 1970 taken modulo 4, 100 and 400
  localparam logic [1:0]  BASE_MOD4    = 2'd2;
  localparam logic [6:0]  BASE_MOD100  = 7'd70;
  localparam logic [8:0]  BASE_MOD400  = 9'd370;

  // restoring-division start bits: top quotient bit index of each split
  localparam logic [2:0]  DAY_TOP_BIT  = 3'd4;
  localparam logic [2:0]  HOUR_TOP_BIT = 3'd4;
  localparam logic [2:0]  MIN_TOP_BIT  = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DAY,
    ST_HOUR,
    ST_MIN
  } state_t;

  // Length of a month in seconds.
  function automatic logic [31:0] month_secs(input logic [3:0] m, input logic leap);
    logic [31:0] days;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: days = 32'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   days = 32'd30;
      4'd1:    days = leap ? 32'd29 : 32'd28;
      default: days = 32'd31;
    endcase
    return days * DAY_SECS;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/epoch_seconds_to_calendar.sv @@
// The year loop steps one year at a time while the remainder holds a whole year, and the
// month loop one month at a time, stopping at December; day, hour and minute then come from
// a restoring division, one quotient bit per cycle (5, 5 and 6 quotient bits).
// Input is accepted only in idle, so conversions do not overlap; a single compare-subtract unit
// does every step, and the last minute bit stalls while an earlier result waits on m_tready.
// Reset (rst, synchronous, active high) returns the sequencer to idle and drops any result.
`default_nettype none

module epoch_seconds_to_calendar (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // [31:0] epoch_seconds
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata    // year[11:0], month_index[15:12], day_of_month[20:16],
                                      // hour[25:21], minute[31:26], second[37:32], zero[39:38]
);

  epcal_pkg::state_t state, state_next;

  logic [31:0] rem, rem_next;
  logic [11:0] year, year_next;
  logic [1:0]  mod4, mod4_next;
  logic [6:0]  mod100, mod100_next;
  logic [8:0]  mod400, mod400_next;
  logic [3:0]  mon, mon_next;
  logic [2:0]  k, k_next;
  logic [4:0]  q, q_next;
  logic [4:0]  day, day_next;
  logic [4:0]  hour, hour_next;
  logic        out_valid, out_valid_next;
  logic [39:0] out_data, out_data_next;

  logic        leap;
  logic [31:0] span;
  logic        ge;
  logic [31:0] diff;
  logic [5:0]  q_shift;
  logic        out_free;

  assign leap = (mod400 == 9'd0) || ((mod100 != 7'd0) && (mod4 == 2'd0));

  // shared compare-subtract unit
  always_comb begin
    unique case (state)
      epcal_pkg::ST_YEAR:  span = leap ? epcal_pkg::LEAP_SECS : epcal_pkg::YEAR_SECS;
      epcal_pkg::ST_MONTH: span = epcal_pkg::month_secs(mon, leap);
      epcal_pkg::ST_DAY:   span = epcal_pkg::DAY_SECS << k;
      epcal_pkg::ST_HOUR:  span = epcal_pkg::HOUR_SECS << k;
      epcal_pkg::ST_MIN:   span = epcal_pkg::MIN_SECS << k;
      default:             span = epcal_pkg::DAY_SECS;
    endcase
  end

  assign ge      = rem >= span;
  assign diff    = rem - span;
  assign q_shift = {q, ge};
  assign out_free = !out_valid || m_tready;

  assign s_tready = (state == epcal_pkg::ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  always_comb begin
    state_next     = state;
    rem_next       = rem;
    year_next      = year;
    mod4_next      = mod4;
    mod100_next    = mod100;
    mod400_next    = mod400;
    mon_next       = mon;
    k_next         = k;
    q_next         = q;
    day_next       = day;
    hour_next      = hour;
    out_data_next  = out_data;
    out_valid_next = out_valid && !m_tready;

    unique case (state)
      epcal_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          rem_next    = s_tdata;
          year_next   = epcal_pkg::BASE_YEAR;
          mod4_next   = epcal_pkg::BASE_MOD4;
          mod100_next = epcal_pkg::BASE_MOD100;
          mod400_next = epcal_pkg::BASE_MOD400;
          mon_next    = 4'd0;
          state_next  = epcal_pkg::ST_YEAR;
        end
      end
      epcal_pkg::ST_YEAR: begin
        if (ge) begin
          rem_next    = diff;
          year_next   = year + 12'd1;
          mod4_next   = mod4 + 2'd1;
          mod100_next = (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
          mod400_next = (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
        end else begin
          state_next = epcal_pkg::ST_MONTH;
        end
      end
      epcal_pkg::ST_MONTH: begin
        if (ge && (mon != epcal_pkg::LAST_MONTH)) begin
          rem_next = diff;
          mon_next = mon + 4'd1;
        end else begin
          k_next     = epcal_pkg::DAY_TOP_BIT;
          q_next     = 5'd0;
          state_next = epcal_pkg::ST_DAY;
        end
      end
      epcal_pkg::ST_DAY: begin
        if (ge) rem_next = diff;
        q_next = q_shift[4:0];
        k_next = k - 3'd1;
        if (k == 3'd0) begin
          day_next   = q_shift[4:0] + 5'd1;
          k_next     = epcal_pkg::HOUR_TOP_BIT;
          q_next     = 5'd0;
          state_next = epcal_pkg::ST_HOUR;
        end
      end
      epcal_pkg::ST_HOUR: begin
        if (ge) rem_next = diff;
        q_next = q_shift[4:0];
        k_next = k - 3'd1;
        if (k == 3'd0) begin
          hour_next  = q_shift[4:0];
          k_next     = epcal_pkg::MIN_TOP_BIT;
          q_next     = 5'd0;
          state_next = epcal_pkg::ST_MIN;
        end
      end
      epcal_pkg::ST_MIN: begin
        // last bit waits until the output register is free
        if ((k != 3'd0) || out_free) begin
          if (ge) rem_next = diff;
          q_next = q_shift[4:0];
          k_next = k - 3'd1;
          if (k == 3'd0) begin
            out_data_next  = {2'b00, (ge ? diff[5:0] : rem[5:0]), q_shift,
                              hour, day, mon, year};
            out_valid_next = 1'b1;
            state_next     = epcal_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = epcal_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= epcal_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rem      <= rem_next;
    year     <= year_next;
    mod4     <= mod4_next;
    mod100   <= mod100_next;
    mod400   <= mod400_next;
    mon      <= mon_next;
    k        <= k_next;
    q        <= q_next;
    day      <= day_next;
    hour     <= hour_next;
    out_data <= out_data_next;
  end

  // mod4 residue tracks the year counter
  a_mod4_track: assert property (@(posedge clk) disable iff (rst)
    (state != epcal_pkg::ST_IDLE) |-> (mod4 == year[1:0]))
    else $error("mod4 out of step with year");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    (state == epcal_pkg::ST_YEAR) |-> (year <= 12'd2106))
    else $error("year ran past 2106");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (state == epcal_pkg::ST_MONTH) |-> (mon <= epcal_pkg::LAST_MONTH))
    else $error("month index out of range");

  a_day_rem: assert property (@(posedge clk) disable iff (rst)
    ((state == epcal_pkg::ST_DAY) && (k == epcal_pkg::DAY_TOP_BIT))
      |-> (rem < (32'd31 * epcal_pkg::DAY_SECS)))
    else $error("remainder exceeds one month after month stripping");

  a_finish_slot: assert property (@(posedge clk) disable iff (rst)
    ((state == epcal_pkg::ST_MIN) && (state_next == epcal_pkg::ST_IDLE))
      |-> (!out_valid || m_tready))
    else $error("result overwrote a pending transfer");

endmodule

`default_nettype wire

@@ sim/epoch_cal_checker.sv @@
module epoch_cal_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,    // [31:0] epoch_seconds
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,    // year, month_index, day_of_month, hour, minute, second, zero
  output int          fail_count,
  output int          pending,
  output int          checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EPOCH_YEAR = 1970;
  localparam int unsigned SECS_DAY   = 86400;
  localparam int unsigned SECS_HOUR  = 3600;
  localparam int unsigned SECS_MIN   = 60;
  localparam int unsigned DECEMBER   = 11;
  localparam int unsigned FEBRUARY   = 1;

  // same layout as m_tdata, lowest field last
  typedef struct packed {
    logic [1:0]  zero;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [11:0] year;
  } cal_t;

  cal_t expected_dates[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    checked    = 0;
  end

  function automatic bit is_leap(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned y, input int unsigned m);
    if (m == FEBRUARY)
      return is_leap(y) ? 29 : 28;
    // Jan..Jul alternate 31/30 from Jan, Aug..Dec alternate 31/30 from Aug
    if (m < 7)
      return (m % 2 == 0) ? 31 : 30;
    return (m % 2 == 0) ? 30 : 31;
  endfunction

  function automatic cal_t calendar_from_epoch(input logic [31:0] secs);
    longint unsigned left;
    int unsigned     yr;
    int unsigned     mo;
    cal_t            r;
    left = secs;
    yr   = EPOCH_YEAR;
    mo   = 0;
    while (left >= longint'(is_leap(yr) ? 366 : 365) * SECS_DAY) begin
      left -= longint'(is_leap(yr) ? 366 : 365) * SECS_DAY;
      yr++;
    end
    while (mo < DECEMBER && left >= longint'(month_days(yr, mo)) * SECS_DAY) begin
      left -= longint'(month_days(yr, mo)) * SECS_DAY;
      mo++;
    end
    r.zero         = '0;
    r.year         = yr[11:0];
    r.month_index  = mo[3:0];
    r.day_of_month = 5'(left / SECS_DAY + 1);
    left           = left % SECS_DAY;
    r.hour         = 5'(left / SECS_HOUR);
    left           = left % SECS_HOUR;
    r.minute       = 6'(left / SECS_MIN);
    r.second       = 6'(left % SECS_MIN);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cal_t got;
    cal_t want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_dates.push_back(calendar_from_epoch(s_tdata));
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_dates.size() == 0) begin
          $error("unexpected result transfer: %h", m_tdata);
          fail_count++;
        end else begin
          want = expected_dates.pop_front();
          check_field("year", want.year, got.year);
          check_field("month_index", want.month_index, got.month_index);
          check_field("day_of_month", want.day_of_month, got.day_of_month);
          check_field("hour", want.hour, got.hour);
          check_field("minute", want.minute, got.minute);
          check_field("second", want.second, got.second);
          check_field("zero", want.zero, got.zero);
          checked++;
        end
      end
    end
    pending <= expected_dates.size();
  end

endmodule

@@ sim/tb_epoch_seconds_to_calendar.sv @@
module tb_epoch_seconds_to_calendar;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM    = 1630;
  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 3000;
  localparam int HOLD_AT     = 300;
  localparam int DRAIN       = 200;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;     // [31:0] epoch_seconds
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;     // year[11:0], month_index[15:12], day_of_month[20:16],
                            // hour[25:21], minute[31:26], second[37:32], zero[39:38]

  int fail_count;
  int pending;
  int checked;
  int stamps_sent;
  int results_taken;
  int idle_cycles;

  // boundaries: minute/hour/day/year edges, leap years 1972 and 2000,
  // non-leap 2100, December, and the largest count
  logic [31:0] corner_secs [] = '{
    32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
    32'd28857599, 32'd28857600, 32'd31535999, 32'd31536000,
    32'd68083200, 32'd68169600, 32'd94694399, 32'd94694400,
    32'd951782400, 32'd951868800, 32'd4107456000, 32'd4107542400,
    32'h7FFFFFFF, 32'h80000000, 32'h55555555, 32'hAAAAAAAA, 32'hFFFFFFFF
  };

  epoch_seconds_to_calendar u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  epoch_cal_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  task automatic send_stamp(input logic [31:0] secs);
    int gap;
    // every 200 items, a stretch of 40 goes back to back
    gap = (stamps_sent % 200 < 40) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= secs;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    stamps_sent++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] random_stamp();
    int unsigned days;
    int unsigned offs;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: begin
        days = $urandom_range(0, 49710);
        case ($urandom_range(0, 3))
          0:       offs = 0;
          1:       offs = 1;
          2:       offs = 86399;
          default: offs = $urandom_range(0, 86399);
        endcase
        return 32'(days * 86400 + offs);
      end
      8:       return 32'hFFFFFFFF - $urandom_range(0, 200000);
      default: return $urandom_range(0, 100000000);
    endcase
  endfunction

  // result side: random stalls, a back-to-back stretch, and one long hold-off
  initial begin
    int n;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (results_taken == HOLD_AT)
        n = HOLD_CYCLES;
      else if (results_taken % 250 < 50)
        n = 0;
      else
        n = $urandom_range(0, 9);
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      results_taken++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    stamps_sent   = 0;
    results_taken = 0;
    idle_cycles   = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (corner_secs[i])
      send_stamp(corner_secs[i]);
    repeat (N_RANDOM)
      send_stamp(random_stamp());
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d timestamps (%0d edge cases, rest random), %0d dates compared.",
             stamps_sent, corner_secs.size(), checked);
    $display("Covered year/month/day boundaries, leap rules, the full 32-bit range and stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
